FILE: sv/keypad_scan_debounce_core_macros.svh
// assertion macros shared by the keypad scan debounce modules
// expects clk and rst_n in the scope where a macro is used
`ifndef KEYPAD_SCAN_DEBOUNCE_CORE_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_CORE_MACROS_SVH

// same-cycle implication
`define KPSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KPSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/kpsd_pkg.sv
// shared types and constants for the keypad scan debounce core
// no dependencies
package kpsd_pkg;

    localparam int COLUMNS    = 7;
    localparam int KEY_COUNT  = 2 * COLUMNS;
    localparam int KEY_W      = $clog2(KEY_COUNT + 1);
    localparam int CNT_W      = 8;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COLUMNS-1:0] cols_t;
    typedef logic [KEY_COUNT-1:0] key_mask_t;
    typedef logic [APB_ADDR_W-1:0] apb_addr_t;
    typedef logic [APB_DATA_W-1:0] apb_data_t;

    localparam key_t      NONE_CODE     = key_t'(KEY_COUNT);
    localparam cnt_t      CONFIRM_RESET = cnt_t'(5);
    localparam apb_addr_t ADDR_CONFIRM  = apb_addr_t'(0);

    typedef struct packed {
        logic confirmed_next;
        logic fire;
    } lane_status_t;

endpackage

FILE: sv/kpsd_lane.sv
// one key lane: seen bit, hold counter and confirmed bit
// depends on kpsd_pkg and keypad_scan_debounce_core_macros.svh
`include "keypad_scan_debounce_core_macros.svh"
module kpsd_lane
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   level,
    input  kpsd_pkg::cnt_t         confirm_count,
    output logic                   confirmed,
    output kpsd_pkg::lane_status_t status
);
    import kpsd_pkg::*;

    logic seen_reg;
    logic seen_next;
    logic conf_reg;
    logic conf_next;
    cnt_t cnt_reg;
    cnt_t cnt_next;
    cnt_t cnt_inc;
    logic fire;

    assign cnt_inc = cnt_reg + cnt_t'(1);

    always_comb
    begin
        seen_next = seen_reg;
        conf_next = conf_reg;
        cnt_next  = cnt_reg;
        fire      = 1'b0;
        if (!level)
        begin
            seen_next = 1'b0;
            conf_next = 1'b0;
            cnt_next  = '0;
        end
        else if (!seen_reg)
        begin
            seen_next = 1'b1;
        end
        else if (!conf_reg)
        begin
            if (cnt_inc >= confirm_count)
            begin
                cnt_next  = '0;
                conf_next = 1'b1;
                fire      = 1'b1;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            conf_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (advance)
        begin
            seen_reg <= seen_next;
            conf_reg <= conf_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign confirmed             = conf_reg;
    assign status.confirmed_next = conf_next;
    assign status.fire           = fire;

    `KPSD_ASSERT_SAME(a_conf_needs_seen, conf_reg, seen_reg, "confirmed key without seen bit")
    `KPSD_ASSERT_NEXT(a_low_clears, advance && !level, (cnt_reg == '0) && !conf_reg && !seen_reg,
        "low level did not clear the lane")

endmodule

FILE: sv/kpsd_merge.sv
// merge stage: picks the highest newly confirmed key and holds the recent key
// depends on kpsd_pkg
module kpsd_merge
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         advance,
    input  kpsd_pkg::lane_status_t [kpsd_pkg::KEY_COUNT-1:0] status,
    output kpsd_pkg::key_t                               last_key
);
    import kpsd_pkg::*;

    key_t recent_reg;
    key_t recent_next;
    key_t fire_idx;
    logic any_fire;
    logic any_conf;

    always_comb
    begin
        fire_idx = '0;
        any_fire = 1'b0;
        any_conf = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (status[k].fire)
            begin
                fire_idx = key_t'(k);
                any_fire = 1'b1;
            end
            if (status[k].confirmed_next)
            begin
                any_conf = 1'b1;
            end
        end
        if (!any_conf)
        begin
            recent_next = NONE_CODE;
        end
        else if (any_fire)
        begin
            recent_next = fire_idx;
        end
        else
        begin
            recent_next = recent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= NONE_CODE;
        end
        else if (advance)
        begin
            recent_reg <= recent_next;
        end
    end

    assign last_key = recent_reg;

endmodule

FILE: sv/keypad_scan_debounce_core.sv
// keypad scan debounce core: 14 key lanes, merge stage, apb register, output valid
// depends on kpsd_pkg, kpsd_lane, kpsd_merge and keypad_scan_debounce_core_macros.svh
// a result beat appears in the cycle after its input beat is accepted
// throughput: one beat per cycle unless out_ready stalls the output, all key lanes update in the same cycle
// a new beat is taken while the output beat is taken in the same cycle
// reset: lanes cleared, last key reads none, confirm_count returns to 5
`include "keypad_scan_debounce_core_macros.svh"
module keypad_scan_debounce_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  kpsd_pkg::apb_addr_t paddr,
    input  kpsd_pkg::apb_data_t pwdata,
    output kpsd_pkg::apb_data_t prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  kpsd_pkg::cols_t     row_one_columns,
    input  kpsd_pkg::cols_t     row_two_columns,
    output logic                out_valid,
    input  logic                out_ready,
    output kpsd_pkg::key_mask_t confirmed_mask,
    output kpsd_pkg::key_t      last_key
);
    import kpsd_pkg::*;

    cnt_t         confirm_count_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         advance;
    key_mask_t    levels;
    lane_status_t [KEY_COUNT-1:0] status;

    // apb register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_count_reg <= CONFIRM_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_CONFIRM))
        begin
            confirm_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_CONFIRM) ? apb_data_t'(confirm_count_reg) : '0;

    // beat handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign levels    = {row_two_columns, row_one_columns};

    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_lane
        kpsd_lane u_lane
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .level         (levels[k]),
            .confirm_count (confirm_count_reg),
            .confirmed     (confirmed_mask[k]),
            .status        (status[k])
        );
    end

    kpsd_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .status   (status),
        .last_key (last_key)
    );

    `KPSD_ASSERT_SAME(a_key_needs_mask, last_key != NONE_CODE, confirmed_mask != '0,
        "last key set with empty confirmed mask")
    `KPSD_ASSERT_SAME(a_key_range, 1'b1, last_key <= NONE_CODE, "last key out of range")
    `KPSD_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input stalled with output empty")

endmodule
